### rtl/core/ltf_pkg.sv
// Shared types and constants for the linear trend usage forecast core.
// No dependencies.
package ltf_pkg;

  localparam int unsigned WIDE_W    = 128;  // width of the solve arithmetic
  localparam int unsigned MUL_BW    = 37;   // narrow operand of the serial multiplier
  localparam int unsigned CNT_W     = 12;
  localparam int unsigned X_W       = 20;
  localparam int unsigned HX_W      = 26;
  // ceil(2^40 / 225): (secs >> 4) * HOUR_RECIP >> 40 gives whole hours, exact for 36-bit secs
  localparam logic [36:0]  HOUR_RECIP = 37'd4886718346;
  localparam logic [19:0]  X_MAX    = 20'hFFFFF;

  typedef enum logic [3:0] {
    OP_HRS_X,     // hours of the sample offset
    OP_MUL_XY,
    OP_MUL_XX,
    OP_MUL_NSX2,
    OP_MUL_SXSX,
    OP_MUL_NSXY,
    OP_MUL_SXSY,
    OP_DIV_SLOPE,
    OP_HRS_NOW,
    OP_MUL_NHX,
    OP_MUL_NUMM,
    OP_MUL_SYDLO,
    OP_MUL_SYDHI,
    OP_MUL_ND,
    OP_DIV_PRED
  } ltf_op_t;

  typedef struct packed {
    ltf_op_t op;
    logic    go_mul;
    logic    go_div;
    logic    load;    // latch the input word
    logic    fix;     // force degenerate fit to zero slope
    logic    emit;    // publish result and clear the run
  } ltf_cmd_t;

  typedef struct packed {
    logic take;       // live input word carries a sample that fits
    logic last_in;    // live input word closes the run
    logic empty;      // no sample in the run
    logic last_r;     // latched word closes the run
    logic mul_done;
    logic div_done;
    logic p_pos;      // prediction numerator above zero
    logic out_free;
  } ltf_sts_t;

  function automatic logic ltf_is_div(input ltf_op_t op);
    return (op == OP_DIV_SLOPE) || (op == OP_DIV_PRED);
  endfunction

  function automatic logic [127:0] ltf_abs(input logic [127:0] v);
    return v[127] ? (~v + 128'd1) : v;
  endfunction

endpackage

### rtl/core/ltf_if.sv
// Valid/ready channel interfaces for the forecast core.
// Depends on nothing.
interface ltf_in_if;
  logic        valid;
  logic        ready;
  logic        carries_sample;
  logic [35:0] sample_time_s;
  logic [31:0] sample_bytes;
  logic [35:0] now_time_s;
  logic        is_last;
  modport source (output valid, carries_sample, sample_time_s, sample_bytes, now_time_s,
                  is_last, input ready);
  modport sink (input valid, carries_sample, sample_time_s, sample_bytes, now_time_s,
                is_last, output ready);
endinterface

interface ltf_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [47:0]        forecast_bytes;
  logic signed [63:0] slope_q16;
  logic [11:0]        fit_count;
  logic [15:0]        horizon_echo;
  modport source (output valid, status, forecast_bytes, slope_q16, fit_count,
                  horizon_echo, input ready);
  modport sink (input valid, status, forecast_bytes, slope_q16, fit_count,
                horizon_echo, output ready);
endinterface

### rtl/core/linear_trend_usage_forecast_core.sv
// Top level of the linear trend usage forecast core.
// Depends on ltf_pkg, ltf_if, ltf_ctrl, ltf_dp.
//
//  port     | direction | carries
//  in_if    | sink      | one word: sample flag, time, bytes, now, last flag
//  out_if   | source    | one word per run: status, forecast, slope, count, horizon
//  cfg_*    | write     | horizon in days
//
// A sample word is accepted, then makes three passes of the serial multiplier (hours by
// reciprocal, x*y, x*x) before in_if.ready rises again. A word without a sample makes no pass.
// The closing solve then runs ten multiplies and up to two 128-step divides.
// Reset is synchronous, active low; the result register holds while out_if.ready is low,
// the next run may be taken meanwhile, and its result waits until the register is free.
module linear_trend_usage_forecast_core #(
  parameter int unsigned SAMPLE_LIMIT = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  ltf_in_if.sink      in_if,
  ltf_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import ltf_pkg::*;

  ltf_cmd_t cmd;
  ltf_sts_t sts;
  logic [63:0] slope;

  ltf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_if.valid),
    .in_ready(in_if.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ltf_dp #(.SAMPLE_LIMIT(SAMPLE_LIMIT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_carries (in_if.carries_sample),
    .in_time    (in_if.sample_time_s),
    .in_bytes   (in_if.sample_bytes),
    .in_now     (in_if.now_time_s),
    .in_last    (in_if.is_last),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .out_status (out_if.status),
    .out_pred   (out_if.forecast_bytes),
    .out_slope  (slope),
    .out_count  (out_if.fit_count),
    .out_horizon(out_if.horizon_echo)
  );

  assign out_if.slope_q16 = $signed(slope);

endmodule

### rtl/core/ltf_mul.sv
// Serial multiplier: 128-bit operand times 37-bit operand, one 32-bit chunk a cycle.
// Depends on ltf_pkg.
module ltf_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [127:0] a,
  input  logic [36:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  import ltf_pkg::*;

  logic [127:0] a_r, acc_r;
  logic [36:0]  b_r;
  logic [68:0]  pp_r;
  logic [2:0]   cnt_r;
  logic         busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd4);
      if (go) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // top chunk first, so the running sum shifts up one chunk a step
        if (cnt_r != 3'd4) begin
          pp_r <= 69'(a_r[127:96]) * 69'(b_r);
          a_r  <= {a_r[95:0], 32'd0};
        end
        if (cnt_r != 3'd0) acc_r <= {acc_r[95:0], 32'd0} + 128'(pp_r);
        if (cnt_r == 3'd4) busy_r <= 1'b0;
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/core/ltf_div.sv
// Restoring divider, one quotient bit a cycle over 128 steps.
// Depends on ltf_pkg.
module ltf_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic         done,
  output logic [127:0] quo
);
  import ltf_pkg::*;

  logic [127:0] n_r, d_r, r_r, q_r, rs, rn;
  logic [6:0]   cnt_r;
  logic         busy_r, done_r, ge;

  always_comb begin
    rs = {r_r[126:0], n_r[127]};
    ge = (rs >= d_r);
    rn = ge ? (rs - d_r) : rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'd0);
      if (go) begin
        n_r    <= num;
        d_r    <= den;
        r_r    <= '0;
        q_r    <= '0;
        cnt_r  <= 7'(WIDE_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r   <= {n_r[126:0], 1'b0};
        r_r   <= rn;
        q_r   <= {q_r[126:0], ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### rtl/core/ltf_dp.sv
// Datapath: run sums, solve registers, result register, shared multiplier and divider.
// Depends on ltf_pkg, ltf_mul, ltf_div.
module ltf_dp #(
  parameter int unsigned SAMPLE_LIMIT = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ltf_pkg::ltf_cmd_t cmd,
  output ltf_pkg::ltf_sts_t sts,
  input  logic              in_carries,
  input  logic [35:0]       in_time,
  input  logic [31:0]       in_bytes,
  input  logic [35:0]       in_now,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_status,
  output logic [47:0]       out_pred,
  output logic [63:0]       out_slope,
  output logic [11:0]       out_count,
  output logic [15:0]       out_horizon
);
  import ltf_pkg::*;

  localparam logic [11:0] MAX_CNT = 12'(SAMPLE_LIMIT);

  logic [15:0]  hd_r;
  logic [11:0]  cnt_r;
  logic [35:0]  org_r, t_r, now_r;
  logic [31:0]  y_r;
  logic         last_r;
  logic [19:0]  x_r;
  logic [30:0]  sx_r;
  logic [42:0]  sy_r;
  logic [62:0]  sxy_r;
  logic [50:0]  sx2_r;
  logic [127:0] t1_r, num_r, den_r, m_r, p_r;
  logic [25:0]  hx_r;
  logic [63:0]  slope_r;
  logic [47:0]  pred_r;
  logic         ov_r, os_r;
  logic [47:0]  op_r;
  logic [63:0]  osl_r;
  logic [11:0]  oc_r;
  logic [15:0]  oh_r;

  logic [127:0] mul_a, div_n, div_d, mul_p, quo, num_abs, m_abs;
  logic [36:0]  mul_b;
  logic         mul_done, div_done;
  logic [35:0]  dt;

  assign num_abs = ltf_abs(num_r);
  assign m_abs   = ltf_abs(m_r);

  // hours offset clamps at zero when the time precedes the origin
  assign dt = (cmd.op == OP_HRS_NOW) ? ((now_r >= org_r) ? now_r - org_r : '0)
                                     : ((t_r >= org_r) ? t_r - org_r : '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_HRS_X,
      OP_HRS_NOW:   begin mul_a = 128'(dt[35:4]); mul_b = HOUR_RECIP;    end
      OP_MUL_XY:    begin mul_a = 128'(y_r);   mul_b = 37'(x_r);           end
      OP_MUL_XX:    begin mul_a = 128'(x_r);   mul_b = 37'(x_r);           end
      OP_MUL_NSX2:  begin mul_a = 128'(sx2_r); mul_b = 37'(cnt_r);         end
      OP_MUL_SXSX:  begin mul_a = 128'(sx_r);  mul_b = 37'(sx_r);          end
      OP_MUL_NSXY:  begin mul_a = 128'(sxy_r); mul_b = 37'(cnt_r);         end
      OP_MUL_SXSY:  begin mul_a = 128'(sy_r);  mul_b = 37'(sx_r);          end
      OP_MUL_NHX:   begin mul_a = 128'(hx_r);  mul_b = 37'(cnt_r);         end
      OP_MUL_NUMM:  begin mul_a = num_abs;     mul_b = m_abs[36:0];        end
      OP_MUL_SYDLO: begin mul_a = 128'(sy_r);  mul_b = 37'(den_r[31:0]);   end
      OP_MUL_SYDHI: begin mul_a = 128'(sy_r);  mul_b = 37'(den_r[63:32]);  end
      OP_MUL_ND:    begin mul_a = den_r;       mul_b = 37'(cnt_r);         end
      default:      begin mul_a = '0;          mul_b = '0;                 end
    endcase
  end

  always_comb begin
    div_n = p_r;
    div_d = t1_r;
    if (cmd.op == OP_DIV_SLOPE) begin
      div_n = (num_abs << 20) + (num_abs << 19);  // times 24 * 65536
      div_d = den_r;
    end
  end

  ltf_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.go_mul),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_p)
  );

  ltf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.go_div),
    .num       (div_n),
    .den       (div_d),
    .done      (div_done),
    .quo       (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r   <= '0;
      cnt_r  <= '0;
      org_r  <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      sxy_r  <= '0;
      sx2_r  <= '0;
      last_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) hd_r <= cfg_wdata;
      if (out_ready) ov_r <= 1'b0;
      if (cmd.load) begin
        t_r    <= in_time;
        y_r    <= in_bytes;
        now_r  <= in_now;
        last_r <= in_last;
        if (sts.take && (cnt_r == '0)) org_r <= in_time;
      end
      if (mul_done) begin
        unique case (cmd.op)
          OP_HRS_X:   x_r <= (mul_p[127:60] != '0) ? X_MAX : mul_p[59:40];
          OP_HRS_NOW: hx_r <= mul_p[65:40] + {6'd0, hd_r, 4'd0} + {7'd0, hd_r, 3'd0};
          OP_MUL_XY: sxy_r <= sxy_r + mul_p[62:0];
          OP_MUL_XX: begin
            sx2_r <= sx2_r + mul_p[50:0];
            sx_r  <= sx_r + 31'(x_r);
            sy_r  <= sy_r + 43'(y_r);
            cnt_r <= cnt_r + 12'd1;
          end
          OP_MUL_NSX2:  t1_r  <= mul_p;
          OP_MUL_SXSX:  den_r <= t1_r - mul_p;
          OP_MUL_NSXY:  t1_r  <= mul_p;
          OP_MUL_SXSY:  num_r <= t1_r - mul_p;
          OP_MUL_NHX:   m_r   <= mul_p - 128'(sx_r);
          OP_MUL_NUMM:  p_r   <= (num_r[127] ^ m_r[127]) ? (~mul_p + 128'd1) : mul_p;
          OP_MUL_SYDLO: p_r   <= p_r + mul_p;
          OP_MUL_SYDHI: p_r   <= p_r + {mul_p[95:0], 32'd0};
          OP_MUL_ND:    t1_r  <= mul_p;
          default:      t1_r  <= t1_r;
        endcase
      end
      if (div_done) begin
        unique case (cmd.op)
          OP_DIV_SLOPE: begin
            if (num_r[127]) begin
              if ((quo[127:64] != '0) || (quo[63:0] > 64'h8000_0000_0000_0000))
                slope_r <= 64'h8000_0000_0000_0000;
              else
                slope_r <= ~quo[63:0] + 64'd1;
            end else begin
              slope_r <= (quo[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
            end
          end
          OP_DIV_PRED: pred_r <= (quo[127:48] != '0) ? 48'hFFFF_FFFF_FFFF : quo[47:0];
          default: pred_r <= pred_r;
        endcase
      end
      if (cmd.fix) begin
        pred_r <= '0;
        if ((cnt_r < 12'd2) || den_r[127] || (den_r == '0)) begin
          num_r <= '0;
          den_r <= 128'd1;
        end
      end
      if (cmd.emit) begin
        ov_r   <= 1'b1;
        os_r   <= (cnt_r == '0);
        op_r   <= (cnt_r == '0) ? '0 : pred_r;
        osl_r  <= (cnt_r == '0) ? '0 : slope_r;
        oc_r   <= cnt_r;
        oh_r   <= (cnt_r == '0) ? '0 : hd_r;
        cnt_r  <= '0;
        org_r  <= '0;
        sx_r   <= '0;
        sy_r   <= '0;
        sxy_r  <= '0;
        sx2_r  <= '0;
      end
    end
  end

  always_comb begin
    sts.take     = in_carries && (cnt_r < MAX_CNT);
    sts.last_in  = in_last;
    sts.empty    = (cnt_r == '0);
    sts.last_r   = last_r;
    sts.mul_done = mul_done;
    sts.div_done = div_done;
    sts.p_pos    = !p_r[127] && (p_r != '0);
    sts.out_free = !ov_r || out_ready;
  end

  assign out_valid   = ov_r;
  assign out_status  = os_r;
  assign out_pred    = op_r;
  assign out_slope   = osl_r;
  assign out_count   = oc_r;
  assign out_horizon = oh_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAX_CNT)
    else $error("sample count beyond capacity");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!ov_r || out_ready))
    else $error("result emitted over an untaken word");
  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("both arithmetic units finished together");

endmodule

### rtl/core/ltf_ctrl.sv
// Controller: sequences sample accumulation and the final least-squares solve.
// Depends on ltf_pkg.
module ltf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ltf_pkg::ltf_sts_t sts,
  output ltf_pkg::ltf_cmd_t cmd
);
  import ltf_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_WAIT, ST_FIX, ST_PCHK, ST_EMIT} state_t;

  state_t  state_r;
  ltf_op_t op_r;
  logic    go_mul_r, go_div_r, accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_r     <= OP_HRS_X;
      go_mul_r <= 1'b0;
      go_div_r <= 1'b0;
    end else begin
      go_mul_r <= 1'b0;
      go_div_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (sts.take) begin
              op_r <= OP_HRS_X; go_mul_r <= 1'b1; state_r <= ST_WAIT;
            end else if (sts.last_in) begin
              if (sts.empty) begin
                state_r <= ST_EMIT;
              end else begin
                op_r <= OP_MUL_NSX2; go_mul_r <= 1'b1; state_r <= ST_WAIT;
              end
            end
          end
        end
        ST_WAIT: begin
          if (sts.mul_done || sts.div_done) begin
            priority case (op_r)
              OP_HRS_X:     begin op_r <= OP_MUL_XY;    go_mul_r <= 1'b1; end
              OP_MUL_XY:    begin op_r <= OP_MUL_XX;    go_mul_r <= 1'b1; end
              OP_MUL_XX: begin
                if (sts.last_r) begin
                  op_r <= OP_MUL_NSX2; go_mul_r <= 1'b1;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
              OP_MUL_NSX2:  begin op_r <= OP_MUL_SXSX;  go_mul_r <= 1'b1; end
              OP_MUL_SXSX:  begin op_r <= OP_MUL_NSXY;  go_mul_r <= 1'b1; end
              OP_MUL_NSXY:  begin op_r <= OP_MUL_SXSY;  go_mul_r <= 1'b1; end
              OP_MUL_SXSY:  state_r <= ST_FIX;
              OP_DIV_SLOPE: begin op_r <= OP_HRS_NOW;   go_mul_r <= 1'b1; end
              OP_HRS_NOW:   begin op_r <= OP_MUL_NHX;   go_mul_r <= 1'b1; end
              OP_MUL_NHX:   begin op_r <= OP_MUL_NUMM;  go_mul_r <= 1'b1; end
              OP_MUL_NUMM:  begin op_r <= OP_MUL_SYDLO; go_mul_r <= 1'b1; end
              OP_MUL_SYDLO: begin op_r <= OP_MUL_SYDHI; go_mul_r <= 1'b1; end
              OP_MUL_SYDHI: begin op_r <= OP_MUL_ND;    go_mul_r <= 1'b1; end
              OP_MUL_ND:    state_r <= ST_PCHK;
              default:      state_r <= ST_EMIT;
            endcase
          end
        end
        ST_FIX: begin
          op_r <= OP_DIV_SLOPE; go_div_r <= 1'b1; state_r <= ST_WAIT;
        end
        ST_PCHK: begin
          // non-positive numerator: prediction stays at zero
          if (sts.p_pos) begin
            op_r <= OP_DIV_PRED; go_div_r <= 1'b1; state_r <= ST_WAIT;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts.out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.op     = op_r;
    cmd.go_mul = go_mul_r;
    cmd.go_div = go_div_r;
    cmd.load   = accept;
    cmd.fix    = (state_r == ST_FIX);
    cmd.emit   = (state_r == ST_EMIT) && sts.out_free;
  end

  a_go_excl: assert property (@(posedge clk) disable iff (!rst_n) !(go_mul_r && go_div_r))
    else $error("both units started together");
  a_go_unit: assert property (@(posedge clk) disable iff (!rst_n)
    go_div_r |-> ltf_is_div(op_r))
    else $error("divider started on a multiply step");
  a_go_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (go_mul_r || go_div_r) |-> (state_r == ST_WAIT))
    else $error("unit started outside the wait state");

endmodule
